// ===== rtl/bpfs_pkg.sv =====
// bpfs_pkg: widths, stage positions, constants and register codes for the
// blinn-phong fragment shader; no dependencies
package bpfs_pkg;

    localparam int POS_W    = 32;
    localparam int COL_W    = 16;
    localparam int LC_W     = 48;
    localparam int VEC_W    = 35;
    localparam int MAG_W    = 34;
    localparam int LEAD_W   = 6;
    localparam int M_W      = 30;
    localparam int SQ_W     = 60;
    localparam int SUM_W    = 62;
    localparam int ROOT_W   = 31;
    localparam int SQ_REM_W = 33;
    localparam int Q_W      = 31;
    localparam int DV_REM_W = 32;
    localparam int UNIT_W   = 32;
    localparam int FRAC     = 30;
    localparam int DOT_W    = 64;
    localparam int FACT_W   = 32;
    localparam int LIT_W    = 18;
    localparam int ADDR_W   = 6;
    localparam int DATA_W   = 64;

    localparam int NORM_LAT = 4 + ROOT_W + Q_W + 1;
    localparam int SPEC_POW_STEPS = 6;

    localparam int ST_IN     = 1;
    localparam int ST_N1     = ST_IN + NORM_LAT;
    localparam int ST_HIN    = ST_N1 + 1;
    localparam int ST_DSUM   = ST_HIN + 1;
    localparam int ST_DCLAMP = ST_DSUM + 1;
    localparam int ST_H      = ST_HIN + NORM_LAT;
    localparam int ST_SPROD  = ST_H + 1;
    localparam int ST_SSUM   = ST_SPROD + 1;
    localparam int ST_SCLAMP = ST_SSUM + 1;
    localparam int ST_SPOW   = ST_SCLAMP + SPEC_POW_STEPS;
    localparam int ST_FACT   = ST_SPOW + 1;
    localparam int ST_LIGHT  = ST_FACT + 1;
    localparam int ST_OUT    = ST_LIGHT + 1;

    localparam logic [FACT_W-1:0] AMBIENT_Q30 = 32'd161061274;
    localparam logic [Q_W-1:0]    ONE_Q30     = 31'h4000_0000;
    localparam logic [COL_W-1:0]  WHITE_Q14   = 16'd16384;
    localparam logic [COL_W-1:0]  COL_MAX     = 16'hFFFF;

    typedef logic [2:0][VEC_W-1:0]  t_vin;
    typedef logic [2:0][UNIT_W-1:0] t_vout;

    typedef struct packed {
        logic             shadow;
        logic [COL_W-1:0] red;
        logic [COL_W-1:0] green;
        logic [COL_W-1:0] blue;
    } t_side;

    typedef enum logic [2:0] {
        REG_LIGHT_X = 3'd0,
        REG_LIGHT_Y = 3'd1,
        REG_LIGHT_Z = 3'd2,
        REG_EYE_X   = 3'd3,
        REG_EYE_Y   = 3'd4,
        REG_EYE_Z   = 3'd5,
        REG_COLOUR  = 3'd6,
        REG_TEX_EN  = 3'd7
    } t_reg_idx;

endpackage

// ===== rtl/bpfs_norm.sv =====
// bpfs_norm: pipelined vector normalizer to q1.30, restoring square root and
// restoring divide one bit per stage; depends on bpfs_pkg
module bpfs_norm import bpfs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_vin  i_vec,
    output t_vout o_unit
);

    logic [2:0][MAG_W-1:0] r1_m;
    logic [2:0]            r1_neg;
    logic [MAG_W-1:0]      r1_mx;
    logic [2:0][M_W-1:0]   r2_m;
    logic [2:0]            r2_neg;
    logic                  r2_zero;
    logic [2:0][SQ_W-1:0]  r3_sq;
    logic [2:0][M_W-1:0]   r3_m;
    logic [2:0]            r3_neg;
    logic                  r3_zero;

    logic [SUM_W-1:0]      r_sq_x    [0:ROOT_W];
    logic [SQ_REM_W-1:0]   r_sq_rem  [0:ROOT_W];
    logic [ROOT_W-1:0]     r_sq_root [0:ROOT_W];
    logic [2:0][M_W-1:0]   r_sq_m    [0:ROOT_W];
    logic [2:0]            r_sq_neg  [0:ROOT_W];
    logic                  r_sq_zero [0:ROOT_W];
    logic [SUM_W-1:0]      n_sq_x    [0:ROOT_W-1];
    logic [SQ_REM_W-1:0]   n_sq_rem  [0:ROOT_W-1];
    logic [ROOT_W-1:0]     n_sq_root [0:ROOT_W-1];

    logic [2:0][DV_REM_W-1:0] r_dv_rem  [1:Q_W];
    logic [2:0][Q_W-1:0]      r_dv_q    [1:Q_W];
    logic [2:0]               r_dv_b    [1:Q_W];
    logic [ROOT_W-1:0]        r_dv_len  [1:Q_W];
    logic [2:0]               r_dv_neg  [1:Q_W];
    logic                     r_dv_zero [1:Q_W];
    logic [2:0][DV_REM_W-1:0] c_dv_rem  [0:Q_W-1];
    logic [2:0][Q_W-1:0]      c_dv_q    [0:Q_W-1];
    logic [2:0]               c_dv_b    [0:Q_W-1];
    logic [ROOT_W-1:0]        c_dv_len  [0:Q_W-1];
    logic [2:0]               c_dv_neg  [0:Q_W-1];
    logic                     c_dv_zero [0:Q_W-1];
    logic [2:0][DV_REM_W-1:0] n_dv_rem  [0:Q_W-1];
    logic [2:0][Q_W-1:0]      n_dv_q    [0:Q_W-1];

    logic [2:0][MAG_W-1:0] n1_m;
    logic [2:0]            n1_neg;
    logic [MAG_W-1:0]      n1_mx;
    logic [2:0][M_W-1:0]   n2_m;
    logic [LEAD_W-1:0]     lead;
    t_vout                 r_unit;
    t_vout                 n_unit;

    // magnitude and largest magnitude
    always_comb begin
        logic [VEC_W-1:0] a;
        n1_mx = '0;
        for (int i = 0; i < 3; i++) begin
            n1_neg[i] = i_vec[i][VEC_W-1];
            a = n1_neg[i] ? (~i_vec[i] + 1'b1) : i_vec[i];
            n1_m[i] = a[MAG_W-1:0];
            if (n1_m[i] > n1_mx) begin
                n1_mx = n1_m[i];
            end
        end
    end

    // bring the top bit of the largest magnitude to bit 29
    always_comb begin
        logic [MAG_W-1:0] s;
        lead = '0;
        for (int b = 0; b < MAG_W; b++) begin
            if (r1_mx[b]) begin
                lead = LEAD_W'(b);
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (lead > LEAD_W'(M_W - 1)) begin
                s = r1_m[i] >> (lead - LEAD_W'(M_W - 1));
            end else begin
                s = r1_m[i] << (LEAD_W'(M_W - 1) - lead);
            end
            n2_m[i] = s[M_W-1:0];
        end
    end

    // square root, two radicand bits per stage
    always_comb begin
        logic [SQ_REM_W+1:0] re;
        logic [SQ_REM_W+1:0] t;
        for (int k = 0; k < ROOT_W; k++) begin
            re = {r_sq_rem[k], r_sq_x[k][SUM_W-1 -: 2]};
            t  = (SQ_REM_W+2)'({r_sq_root[k], 2'b01});
            n_sq_x[k] = {r_sq_x[k][SUM_W-3:0], 2'b00};
            if (re >= t) begin
                re = re - t;
                n_sq_root[k] = {r_sq_root[k][ROOT_W-2:0], 1'b1};
            end else begin
                n_sq_root[k] = {r_sq_root[k][ROOT_W-2:0], 1'b0};
            end
            n_sq_rem[k] = re[SQ_REM_W-1:0];
        end
    end

    // divide (m << 30) by the length, one quotient bit per stage
    always_comb begin
        logic [DV_REM_W:0] re;
        for (int k = 0; k < Q_W; k++) begin
            if (k == 0) begin
                c_dv_len[k]  = r_sq_root[ROOT_W];
                c_dv_neg[k]  = r_sq_neg[ROOT_W];
                c_dv_zero[k] = r_sq_zero[ROOT_W];
                for (int i = 0; i < 3; i++) begin
                    c_dv_rem[k][i] = DV_REM_W'(r_sq_m[ROOT_W][i] >> 1);
                    c_dv_b[k][i]   = r_sq_m[ROOT_W][i][0];
                    c_dv_q[k][i]   = '0;
                end
            end else begin
                c_dv_len[k]  = r_dv_len[k];
                c_dv_neg[k]  = r_dv_neg[k];
                c_dv_zero[k] = r_dv_zero[k];
                c_dv_rem[k]  = r_dv_rem[k];
                c_dv_b[k]    = r_dv_b[k];
                c_dv_q[k]    = r_dv_q[k];
            end
            for (int i = 0; i < 3; i++) begin
                re = {c_dv_rem[k][i], c_dv_b[k][i]};
                if (re >= (DV_REM_W+1)'(c_dv_len[k])) begin
                    re = re - (DV_REM_W+1)'(c_dv_len[k]);
                    n_dv_q[k][i] = {c_dv_q[k][i][Q_W-2:0], 1'b1};
                end else begin
                    n_dv_q[k][i] = {c_dv_q[k][i][Q_W-2:0], 1'b0};
                end
                n_dv_rem[k][i] = re[DV_REM_W-1:0];
            end
        end
    end

    // sign restore; a zero vector gives a zero result
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_dv_zero[Q_W]) begin
                n_unit[i] = '0;
            end else if (r_dv_neg[Q_W][i]) begin
                n_unit[i] = UNIT_W'(0) - UNIT_W'(r_dv_q[Q_W][i]);
            end else begin
                n_unit[i] = UNIT_W'(r_dv_q[Q_W][i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_m    <= n1_m;
            r1_neg  <= n1_neg;
            r1_mx   <= n1_mx;
            r2_m    <= n2_m;
            r2_neg  <= r1_neg;
            r2_zero <= (r1_mx == '0);
            for (int i = 0; i < 3; i++) begin
                r3_sq[i] <= SQ_W'(r2_m[i]) * SQ_W'(r2_m[i]);
            end
            r3_m    <= r2_m;
            r3_neg  <= r2_neg;
            r3_zero <= r2_zero;

            r_sq_x[0]    <= SUM_W'(r3_sq[0]) + SUM_W'(r3_sq[1]) + SUM_W'(r3_sq[2]);
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_m[0]    <= r3_m;
            r_sq_neg[0]  <= r3_neg;
            r_sq_zero[0] <= r3_zero;
            for (int k = 0; k < ROOT_W; k++) begin
                r_sq_x[k+1]    <= n_sq_x[k];
                r_sq_rem[k+1]  <= n_sq_rem[k];
                r_sq_root[k+1] <= n_sq_root[k];
                r_sq_m[k+1]    <= r_sq_m[k];
                r_sq_neg[k+1]  <= r_sq_neg[k];
                r_sq_zero[k+1] <= r_sq_zero[k];
            end

            for (int k = 0; k < Q_W; k++) begin
                r_dv_rem[k+1]  <= n_dv_rem[k];
                r_dv_q[k+1]    <= n_dv_q[k];
                r_dv_b[k+1]    <= '0;
                r_dv_len[k+1]  <= c_dv_len[k];
                r_dv_neg[k+1]  <= c_dv_neg[k];
                r_dv_zero[k+1] <= c_dv_zero[k];
            end

            r_unit <= n_unit;
        end
    end

    assign o_unit = r_unit;

endmodule

// ===== rtl/blinn_phong_fragment_shade.sv =====
// blinn_phong_fragment_shade: blinn-phong lighting of one fragment per clock while
// the output is not stalled, with an apb register port; depends on bpfs_pkg and bpfs_norm
//
//   channel   handshake                     payload
//   input     i_valid / o_stall             i_frag_*, i_norm_*, i_tex_*, i_in_shadow
//   output    o_valid / i_stall             o_out_red, o_out_green, o_out_blue
//   config    psel penable pwrite pready    paddr, pwdata, prdata
//
// one item per clock while the output is not stalled; the depth is set by two
// normalizers in series, each a 31-stage square root followed by a 31-stage divide
// synchronous active-low reset clears the valid bits and registers (light colour:
// all ones); a stalled output holds the whole pipeline; o_stall follows at once
module blinn_phong_fragment_shade import bpfs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [POS_W-1:0]  i_frag_x,
    input  logic [POS_W-1:0]  i_frag_y,
    input  logic [POS_W-1:0]  i_frag_z,
    input  logic [POS_W-1:0]  i_norm_x,
    input  logic [POS_W-1:0]  i_norm_y,
    input  logic [POS_W-1:0]  i_norm_z,
    input  logic [COL_W-1:0]  i_tex_red,
    input  logic [COL_W-1:0]  i_tex_green,
    input  logic [COL_W-1:0]  i_tex_blue,
    input  logic              i_in_shadow,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [COL_W-1:0]  o_out_red,
    output logic [COL_W-1:0]  o_out_green,
    output logic [COL_W-1:0]  o_out_blue,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [2:0][POS_W-1:0] r_light_pos;
    logic [2:0][POS_W-1:0] r_eye_pos;
    logic [LC_W-1:0]       r_light_colour;
    logic                  r_tex_en;

    logic                  en;
    logic [2:0][POS_W-1:0] frag;
    logic [2:0][POS_W-1:0] norm;
    t_vin                  n_nin, n_lin, n_ein, n_hin;
    t_vin                  r_nin, r_lin, r_ein, r_hin;
    t_vout                 n_unit, l_unit, e_unit, h_unit;

    logic                  r_vld  [ST_IN:ST_OUT];
    t_side                 r_side [ST_IN:ST_LIGHT];
    t_vout                 r_nd   [ST_N1+1:ST_H];
    logic [Q_W-1:0]        r_diff [ST_DCLAMP:ST_SPOW];
    logic [Q_W-1:0]        r_spec [ST_SCLAMP:ST_SPOW];

    logic signed [2:0][DOT_W-1:0] r_dprod, r_sprod;
    logic signed [DOT_W-1:0]      r_dsum, r_ssum;
    logic [FACT_W-1:0]            r_fact;
    logic [2:0][LIT_W-1:0]        r_light;
    logic [2:0][COL_W-1:0]        r_out;

    logic [Q_W-1:0]               n_diff, n_spec0;
    logic [FACT_W-1:0]            n_fact;
    logic [2:0][LIT_W-1:0]        n_light;
    logic [2:0][COL_W-1:0]        n_out;
    logic [2:0][COL_W-1:0]        tex;

    assign en      = !(r_vld[ST_OUT] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[ST_OUT];
    assign pready  = 1'b1;

    assign frag = {i_frag_z, i_frag_y, i_frag_x};
    assign norm = {i_norm_z, i_norm_y, i_norm_x};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_nin[i] = VEC_W'($signed(norm[i]));
            n_lin[i] = VEC_W'($signed(r_light_pos[i])) - VEC_W'($signed(frag[i]));
            n_ein[i] = VEC_W'($signed(r_eye_pos[i])) - VEC_W'($signed(frag[i]));
            n_hin[i] = VEC_W'($signed(l_unit[i])) + VEC_W'($signed(e_unit[i]));
        end
    end

    bpfs_norm u_norm_n (.i_clk(i_clk), .i_en(en), .i_vec(r_nin), .o_unit(n_unit));
    bpfs_norm u_norm_l (.i_clk(i_clk), .i_en(en), .i_vec(r_lin), .o_unit(l_unit));
    bpfs_norm u_norm_e (.i_clk(i_clk), .i_en(en), .i_vec(r_ein), .o_unit(e_unit));
    bpfs_norm u_norm_h (.i_clk(i_clk), .i_en(en), .i_vec(r_hin), .o_unit(h_unit));

    // clamp of dot products to [0, 1.0]
    always_comb begin
        logic [DOT_W-1:0] sd, ss;
        sd = DOT_W'(r_dsum >>> FRAC);
        ss = DOT_W'(r_ssum >>> FRAC);
        if (r_dsum <= 0) begin
            n_diff = '0;
        end else if (sd > DOT_W'(ONE_Q30)) begin
            n_diff = ONE_Q30;
        end else begin
            n_diff = sd[Q_W-1:0];
        end
        if (r_ssum <= 0) begin
            n_spec0 = '0;
        end else if (ss > DOT_W'(ONE_Q30)) begin
            n_spec0 = ONE_Q30;
        end else begin
            n_spec0 = ss[Q_W-1:0];
        end
    end

    always_comb begin
        logic [LC_W-1:0]        lp;
        logic [2*COL_W+1:0]     op;
        logic [COL_W-1:0]       lc;
        logic [COL_W-1:0]       base;
        logic [LIT_W+1:0]       v;
        if (r_side[ST_SPOW].shadow) begin
            n_fact = AMBIENT_Q30;
        end else begin
            n_fact = AMBIENT_Q30 + FACT_W'(r_diff[ST_SPOW]) + FACT_W'(r_spec[ST_SPOW]);
        end
        tex = {r_side[ST_LIGHT].blue, r_side[ST_LIGHT].green, r_side[ST_LIGHT].red};
        for (int i = 0; i < 3; i++) begin
            lc = r_light_colour[LC_W-1-COL_W*i -: COL_W];
            lp = LC_W'(lc) * LC_W'(r_fact);
            n_light[i] = lp[FRAC +: LIT_W];
            base = r_tex_en ? tex[i] : WHITE_Q14;
            op = (2*COL_W+2)'(base) * (2*COL_W+2)'(r_light[i]);
            v = op[2*COL_W+1:14];
            n_out[i] = (v > (LIT_W+2)'(COL_MAX)) ? COL_MAX : v[COL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = ST_IN; k <= ST_OUT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[ST_IN] <= i_valid;
            for (int k = ST_IN + 1; k <= ST_OUT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic [2*Q_W-1:0] sq;
        if (en) begin
            r_nin <= n_nin;
            r_lin <= n_lin;
            r_ein <= n_ein;
            r_side[ST_IN] <= '{shadow: i_in_shadow, red: i_tex_red,
                               green: i_tex_green, blue: i_tex_blue};
            for (int k = ST_IN + 1; k <= ST_LIGHT; k++) begin
                r_side[k] <= r_side[k-1];
            end

            r_hin <= n_hin;
            for (int i = 0; i < 3; i++) begin
                r_dprod[i] <= $signed(l_unit[i]) * $signed(n_unit[i]);
                r_sprod[i] <= $signed(h_unit[i]) * $signed(r_nd[ST_H][i]);
            end
            r_dsum <= r_dprod[0] + r_dprod[1] + r_dprod[2];
            r_ssum <= r_sprod[0] + r_sprod[1] + r_sprod[2];

            r_nd[ST_N1+1] <= n_unit;
            for (int k = ST_N1 + 2; k <= ST_H; k++) begin
                r_nd[k] <= r_nd[k-1];
            end

            r_diff[ST_DCLAMP] <= n_diff;
            for (int k = ST_DCLAMP + 1; k <= ST_SPOW; k++) begin
                r_diff[k] <= r_diff[k-1];
            end

            // n.h raised to the 64th by repeated squaring
            r_spec[ST_SCLAMP] <= n_spec0;
            for (int k = ST_SCLAMP + 1; k <= ST_SPOW; k++) begin
                sq = (2*Q_W)'(r_spec[k-1]) * (2*Q_W)'(r_spec[k-1]);
                r_spec[k] <= sq[FRAC +: Q_W];
            end

            r_fact  <= n_fact;
            r_light <= n_light;
            r_out   <= n_out;
        end
    end

    assign o_out_red   = r_out[0];
    assign o_out_green = r_out[1];
    assign o_out_blue  = r_out[2];

    // register port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_pos    <= '0;
            r_eye_pos      <= '0;
            r_light_colour <= '1;
            r_tex_en       <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (t_reg_idx'(paddr[5:3]))
                REG_LIGHT_X: r_light_pos[0] <= pwdata[POS_W-1:0];
                REG_LIGHT_Y: r_light_pos[1] <= pwdata[POS_W-1:0];
                REG_LIGHT_Z: r_light_pos[2] <= pwdata[POS_W-1:0];
                REG_EYE_X:   r_eye_pos[0]   <= pwdata[POS_W-1:0];
                REG_EYE_Y:   r_eye_pos[1]   <= pwdata[POS_W-1:0];
                REG_EYE_Z:   r_eye_pos[2]   <= pwdata[POS_W-1:0];
                REG_COLOUR:  r_light_colour <= pwdata[LC_W-1:0];
                REG_TEX_EN:  r_tex_en       <= pwdata[0];
                default:     r_tex_en       <= r_tex_en;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[5:3]))
            REG_LIGHT_X: prdata = DATA_W'(r_light_pos[0]);
            REG_LIGHT_Y: prdata = DATA_W'(r_light_pos[1]);
            REG_LIGHT_Z: prdata = DATA_W'(r_light_pos[2]);
            REG_EYE_X:   prdata = DATA_W'(r_eye_pos[0]);
            REG_EYE_Y:   prdata = DATA_W'(r_eye_pos[1]);
            REG_EYE_Z:   prdata = DATA_W'(r_eye_pos[2]);
            REG_COLOUR:  prdata = DATA_W'(r_light_colour);
            REG_TEX_EN:  prdata = DATA_W'(r_tex_en);
            default:     prdata = '0;
        endcase
    end

endmodule
